// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the command line tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the condition.
`define CLT_ASSERT_IMP(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the condition.
`define CLT_ASSERT_NXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- rtl/clt_pkg.sv -----
// Types, codes and character constants of the command line tokenizer.
package clt_pkg;

  localparam int MaxRes = 3;

  // Characters that the scanner recognizes.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Word roles.
  localparam logic [1:0] ROLE_NAME  = 2'd0;
  localparam logic [1:0] ROLE_ARG   = 2'd1;
  localparam logic [1:0] ROLE_KEY   = 2'd2;
  localparam logic [1:0] ROLE_VALUE = 2'd3;

  typedef enum logic [2:0] {
    PH_BETWEEN = 3'd0,
    PH_BARE    = 3'd1,
    PH_VSTART  = 3'd2,
    PH_QUOTED  = 3'd3,
    PH_ESC     = 3'd4,
    PH_CLOSED  = 3'd5
  } clt_phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       line_end;
  } clt_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [1:0] role;
    logic       line_ok;
    logic       last_of_run;
  } clt_out_t;

  typedef struct packed {
    clt_phase_t phase;
    logic       in_value;
    logic       word_quoted;
    logic       have_name;
    logic       arg_filled;
    logic       have_fields;
    logic       word_nonempty;
    logic       error_seen;
  } clt_state_t;

  // All results of one input word, oldest in slot zero.
  typedef struct packed {
    clt_out_t [MaxRes-1:0] res;
    logic [1:0]            cnt;
  } clt_batch_t;

  localparam clt_state_t STATE_RESET = '{
    phase: PH_BETWEEN, in_value: 1'b0, word_quoted: 1'b0, have_name: 1'b0,
    arg_filled: 1'b0, have_fields: 1'b0, word_nonempty: 1'b0, error_seen: 1'b0
  };

  function automatic clt_out_t mk_res(logic [1:0] kind, logic [7:0] ch,
                                      logic [1:0] role, logic ok);
    clt_out_t r;
    r.kind        = kind;
    r.out_char    = ch;
    r.role        = role;
    r.line_ok     = ok;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/clt_decode.sv -----
// Per-character scanner: next parse state and the results of one input word.
module clt_decode (
  input  clt_pkg::clt_state_t state_i,
  input  clt_pkg::clt_in_t    item_i,
  output clt_pkg::clt_state_t state_o,
  output clt_pkg::clt_batch_t batch_o
);
  import clt_pkg::*;

  clt_state_t          st;
  clt_out_t [MaxRes-1:0] res;
  logic [1:0]          n;
  logic [7:0]          c;
  logic                is_sep;

  always_comb begin
    st     = state_i;
    res    = '0;
    n      = 2'd0;
    c      = item_i.char_code;
    is_sep = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);

    if (item_i.has_char && !st.error_seen) begin
      case (st.phase)
        PH_BETWEEN: begin
          if (!is_sep) begin
            if (c == CH_QUOTE) begin
              if (!st.have_name || st.arg_filled || st.have_fields) begin
                st.error_seen = 1'b1;
              end else begin
                st.phase         = PH_QUOTED;
                st.in_value      = 1'b0;
                st.word_quoted   = 1'b1;
                st.word_nonempty = 1'b0;
              end
            end else if (c == CH_EQUAL) begin
              st.error_seen = 1'b1;
            end else begin
              st.phase         = PH_BARE;
              st.in_value      = 1'b0;
              st.word_quoted   = 1'b0;
              st.word_nonempty = 1'b1;
              res[n] = mk_res(KIND_CHAR, c, ROLE_NAME, 1'b0);
              n = n + 2'd1;
            end
          end
        end
        PH_BARE: begin
          if (is_sep) begin
            if (st.in_value) begin
              res[n] = mk_res(KIND_END, 8'h00, ROLE_VALUE, 1'b0);
              n = n + 2'd1;
            end else if (!st.have_name) begin
              st.have_name = 1'b1;
              res[n] = mk_res(KIND_END, 8'h00, ROLE_NAME, 1'b0);
              n = n + 2'd1;
            end else if (!st.arg_filled && !st.have_fields) begin
              st.arg_filled = st.word_nonempty;
              res[n] = mk_res(KIND_END, 8'h00, ROLE_ARG, 1'b0);
              n = n + 2'd1;
            end else begin
              st.error_seen = 1'b1;
            end
            st.phase = PH_BETWEEN;
          end else if (c == CH_QUOTE) begin
            st.error_seen = 1'b1;
          end else if (c == CH_EQUAL) begin
            if (st.in_value) begin
              st.error_seen = 1'b1;
            end else begin
              st.have_fields   = 1'b1;
              res[n] = mk_res(KIND_END, 8'h00, ROLE_KEY, 1'b0);
              n = n + 2'd1;
              st.phase         = PH_VSTART;
              st.in_value      = 1'b1;
              st.word_nonempty = 1'b0;
            end
          end else begin
            st.word_nonempty = 1'b1;
            res[n] = mk_res(KIND_CHAR, c, ROLE_NAME, 1'b0);
            n = n + 2'd1;
          end
        end
        PH_VSTART: begin
          if (c == CH_QUOTE) begin
            st.phase         = PH_QUOTED;
            st.in_value      = 1'b1;
            st.word_quoted   = 1'b1;
            st.word_nonempty = 1'b0;
          end else if (is_sep) begin
            res[n] = mk_res(KIND_END, 8'h00, ROLE_VALUE, 1'b0);
            n = n + 2'd1;
            st.phase = PH_BETWEEN;
          end else if (c == CH_EQUAL) begin
            st.error_seen = 1'b1;
          end else begin
            st.phase         = PH_BARE;
            st.word_quoted   = 1'b0;
            st.word_nonempty = 1'b1;
            res[n] = mk_res(KIND_CHAR, c, ROLE_NAME, 1'b0);
            n = n + 2'd1;
          end
        end
        PH_QUOTED: begin
          if (c == CH_QUOTE) begin
            if (st.in_value) begin
              res[n] = mk_res(KIND_END, 8'h00, ROLE_VALUE, 1'b0);
            end else begin
              st.arg_filled = st.word_nonempty;
              res[n] = mk_res(KIND_END, 8'h00, ROLE_ARG, 1'b0);
            end
            n = n + 2'd1;
            st.phase = PH_CLOSED;
          end else if (c == CH_BSLASH) begin
            st.phase = PH_ESC;
          end else begin
            st.word_nonempty = 1'b1;
            res[n] = mk_res(KIND_CHAR, c, ROLE_NAME, 1'b0);
            n = n + 2'd1;
          end
        end
        PH_ESC: begin
          // A backslash before anything but a quote or backslash is literal,
          // and the following character is then an ordinary quoted character.
          st.word_nonempty = 1'b1;
          st.phase         = PH_QUOTED;
          if ((c == CH_QUOTE) || (c == CH_BSLASH)) begin
            res[n] = mk_res(KIND_CHAR, c, ROLE_NAME, 1'b0);
            n = n + 2'd1;
          end else begin
            res[n] = mk_res(KIND_CHAR, CH_BSLASH, ROLE_NAME, 1'b0);
            n = n + 2'd1;
            res[n] = mk_res(KIND_CHAR, c, ROLE_NAME, 1'b0);
            n = n + 2'd1;
          end
        end
        PH_CLOSED: begin
          if (is_sep) begin
            st.phase = PH_BETWEEN;
          end else begin
            st.error_seen = 1'b1;
          end
        end
        default: begin
          st.error_seen = 1'b1;
        end
      endcase
    end

    if (item_i.line_end) begin
      if (!st.error_seen) begin
        if (st.phase == PH_BARE) begin
          if (st.in_value) begin
            res[n] = mk_res(KIND_END, 8'h00, ROLE_VALUE, 1'b0);
            n = n + 2'd1;
          end else if (!st.have_name) begin
            st.have_name = 1'b1;
            res[n] = mk_res(KIND_END, 8'h00, ROLE_NAME, 1'b0);
            n = n + 2'd1;
          end else if (!st.arg_filled && !st.have_fields) begin
            st.arg_filled = st.word_nonempty;
            res[n] = mk_res(KIND_END, 8'h00, ROLE_ARG, 1'b0);
            n = n + 2'd1;
          end else begin
            st.error_seen = 1'b1;
          end
        end else if (st.phase == PH_VSTART) begin
          res[n] = mk_res(KIND_END, 8'h00, ROLE_VALUE, 1'b0);
          n = n + 2'd1;
        end else if ((st.phase == PH_QUOTED) || (st.phase == PH_ESC)) begin
          st.error_seen = 1'b1;
        end
      end
      res[n] = mk_res(KIND_VERDICT, 8'h00, ROLE_NAME, !st.error_seen && st.have_name);
      n = n + 2'd1;
      st = STATE_RESET;
    end

    for (int i = 0; i < MaxRes; i++) begin
      res[i].last_of_run = (n == 2'(i + 1));
    end

    state_o     = st;
    batch_o.res = res;
    batch_o.cnt = n;
  end

endmodule

// ----- rtl/clt_outbuf.sv -----
// Result buffer that holds the results of one word and sends one per unstalled cycle.
module clt_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_req,
  input  clt_pkg::clt_batch_t batch_i,
  output logic                load,
  output logic [1:0]          cnt,
  output logic                out_valid,
  input  logic                out_stall,
  output clt_pkg::clt_out_t   out_word
);
  import clt_pkg::*;

  clt_out_t [MaxRes-1:0] res_r, res_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  pop;

  assign pop  = (cnt_r != 2'd0) && !out_stall;
  // A new batch goes in when the buffer is empty or its last result leaves in this cycle.
  assign load = load_req && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop));

  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (load) begin
      res_nxt = batch_i.res;
      cnt_nxt = batch_i.cnt;
    end else if (pop) begin
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    res_r <= res_nxt;
  end

  assign cnt       = cnt_r;
  assign out_valid = (cnt_r != 2'd0);
  assign out_word  = res_r[0];

endmodule

// ----- rtl/command_line_tokenizer.sv -----
// Top level of the command line tokenizer: input register, parse state and result buffer.
//
// Usage: the input channel takes one word per cycle while in_stall is low: a byte
// of the command line (char_code, valid when has_char is set) and a line_end flag
// that closes the line after the byte, if any, has been scanned. A word is taken at
// a rising edge where in_valid is high and in_stall is low. The result channel sends
// one word per result: a word character, a word end with its role, or the line
// verdict; last_of_run marks the final result caused by one input word, and an input
// word may cause none or up to three results.
// Results pass through the input register and the result buffer before out_word.
// Throughput: one input word per cycle while each causes at most one result and
// out_stall is low; a word with two or three results holds the input until the buffer
// is down to its last entry, as the single result port drains one entry per cycle.
// Reset (rst_n low, synchronous) empties the input register and result buffer and
// puts the parse state between words with all line flags cleared.
// A stalled receiver keeps the current result on out_word; the buffer then fills
// and in_stall rises once the input register holds a word that cannot move on.
`include "assert_macros.svh"

module command_line_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  clt_pkg::clt_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output clt_pkg::clt_out_t out_word
);
  import clt_pkg::*;

  // Input register: the word being scanned this cycle.
  logic       in_vld_r, in_vld_nxt;
  clt_in_t    in_word_r, in_word_nxt;
  // Parse state of the current line.
  clt_state_t state_r, state_nxt, state_dec;
  clt_batch_t batch;
  logic       load;
  logic [1:0] buf_cnt;
  logic       accept;

  clt_decode u_decode (
    .state_i (state_r),
    .item_i  (in_word_r),
    .state_o (state_dec),
    .batch_o (batch)
  );

  clt_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_req  (in_vld_r),
    .batch_i   (batch),
    .load      (load),
    .cnt       (buf_cnt),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // The input register frees up whenever its word moves into the result buffer.
  assign in_stall = in_vld_r && !load;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_word_nxt = in_word_r;
    state_nxt   = state_r;
    if (load) begin
      in_vld_nxt = 1'b0;
      state_nxt  = state_dec;
    end
    if (accept) begin
      in_vld_nxt  = 1'b1;
      in_word_nxt = in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      state_r  <= STATE_RESET;
    end else begin
      in_vld_r <= in_vld_nxt;
      state_r  <= state_nxt;
    end
    in_word_r <= in_word_nxt;
  end

  // The input is stalled only while it holds a word of its own.
  `CLT_ASSERT_IMP(a_stall_needs_word, !in_vld_r, !in_stall, "stall without a held word")
  // A buffer with more than one pending result cannot take a new batch.
  `CLT_ASSERT_IMP(a_no_overrun, in_vld_r && (buf_cnt > 2'd1), in_stall, "buffer overrun")
  // Every verdict leaves the parse state as after reset.
  `CLT_ASSERT_NXT(a_line_clears, load && in_word_r.line_end, state_r == STATE_RESET, "line state kept")

endmodule
